FILE: rtl/core/lfulru_pkg.sv
// ----------------------------------------------------------------------------
// lfulru_pkg
// Shared types and constants for the LFU page replacer with LRU tie-break.
// ----------------------------------------------------------------------------
package lfulru_pkg;

  localparam int unsigned MAX_FRAMES = 16;
  localparam int unsigned PAGE_SPACE = 64;

  localparam int unsigned FRAME_W = 4;
  localparam int unsigned PAGE_W  = 6;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned CFG_W   = 5;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_idx_t;
  typedef logic [CNT_W-1:0]   use_cnt_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [CFG_W-1:0]   cfg_frames_t;

  localparam cfg_frames_t FRAMES_RESET = 5'd4;
  localparam use_cnt_t    USE_CNT_MAX  = '1;
  localparam stamp_t      STAMP_MAX    = '1;
  localparam total_t      TOTAL_MAX    = '1;

  // One entry of the per-page table: use count and last-use stamp.
  typedef struct packed {
    use_cnt_t cnt;
    stamp_t   stamp;
  } page_rec_t;

  // Result of the frame lookup for the referenced page.
  typedef struct packed {
    logic       found;
    logic       hit;
    frame_idx_t slot;
  } lookup_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_PAGE,
    ST_WR_PAGE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVICT
  } state_t;

endpackage

FILE: rtl/core/lfulru_page_mem.sv
// ----------------------------------------------------------------------------
// lfulru_page_mem
// Per-page record store: one read and one write port, registered read data.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module lfulru_page_mem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  lfulru_pkg::page_t    rd_addr,
  output lfulru_pkg::page_rec_t rd_rec,
  input  logic                 wr_en,
  input  lfulru_pkg::page_t    wr_addr,
  input  lfulru_pkg::page_rec_t wr_rec
);

  lfulru_pkg::page_rec_t rec_mem [lfulru_pkg::PAGE_SPACE];
  logic [lfulru_pkg::PAGE_SPACE-1:0] written_r;
  lfulru_pkg::page_rec_t rd_data_r;
  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_data_r <= rec_mem[rd_addr];
    end
  end

  // Written flags stand in for clearing the store at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_rec = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: rtl/core/lfulru_frame_tbl.sv
// ----------------------------------------------------------------------------
// lfulru_frame_tbl
// Frame registers with the resident/empty lookup and a scan read port.
// ----------------------------------------------------------------------------
module lfulru_frame_tbl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lfulru_pkg::page_t      lk_page,
  input  lfulru_pkg::frame_idx_t nf_last,
  output lfulru_pkg::lookup_t    lk,
  input  lfulru_pkg::frame_idx_t rd_idx,
  output lfulru_pkg::page_t      rd_page,
  input  logic                   wr_en,
  input  lfulru_pkg::frame_idx_t wr_idx,
  input  lfulru_pkg::page_t      wr_page
);

  lfulru_pkg::page_t frame_page_r [lfulru_pkg::MAX_FRAMES];
  logic [lfulru_pkg::MAX_FRAMES-1:0] frame_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_page_r[wr_idx] <= wr_page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_vld_r <= '0;
    end else if (wr_en) begin
      frame_vld_r[wr_idx] <= 1'b1;
    end
  end

  // First in-use frame that is empty or holds the page; walk down so the
  // lowest index wins.
  always_comb begin
    lk = '0;
    for (int j = lfulru_pkg::MAX_FRAMES - 1; j >= 0; j--) begin
      if ((lfulru_pkg::FRAME_W'(j) <= nf_last) &&
          (!frame_vld_r[j] || (frame_page_r[j] == lk_page))) begin
        lk.found = 1'b1;
        lk.hit   = frame_vld_r[j];
        lk.slot  = lfulru_pkg::FRAME_W'(j);
      end
    end
  end

  assign rd_page = frame_page_r[rd_idx];

endmodule

FILE: rtl/core/lfulru_victim_sel.sv
// ----------------------------------------------------------------------------
// lfulru_victim_sel
// Running minimum over scanned frames: least use count, then earliest stamp,
// then lowest frame index.
// ----------------------------------------------------------------------------
module lfulru_victim_sel (
  input  logic                   clk,
  input  logic                   cmp_vld,
  input  lfulru_pkg::frame_idx_t cmp_idx,
  input  lfulru_pkg::page_t      cmp_page,
  input  lfulru_pkg::page_rec_t  cmp_rec,
  output lfulru_pkg::frame_idx_t best_idx,
  output lfulru_pkg::page_t      best_page,
  output lfulru_pkg::stamp_t     best_stamp
);

  lfulru_pkg::frame_idx_t best_idx_r;
  lfulru_pkg::page_t      best_page_r;
  lfulru_pkg::page_rec_t  best_rec_r;
  logic                   take;

  // Strictly smaller only, so an equal later frame never displaces the best.
  always_comb begin
    take = (cmp_idx == '0) ||
           (cmp_rec.cnt < best_rec_r.cnt) ||
           ((cmp_rec.cnt == best_rec_r.cnt) && (cmp_rec.stamp < best_rec_r.stamp));
  end

  always_ff @(posedge clk) begin
    if (cmp_vld && take) begin
      best_idx_r  <= cmp_idx;
      best_page_r <= cmp_page;
      best_rec_r  <= cmp_rec;
    end
  end

  assign best_idx   = best_idx_r;
  assign best_page  = best_page_r;
  assign best_stamp = best_rec_r.stamp;

endmodule

FILE: rtl/core/lfu_lru_page_replacer_top.sv
// ----------------------------------------------------------------------------
// lfu_lru_page_replacer_top
// LFU page replacer with LRU tie-break over a per-page record memory.
// Sequence: RD_PAGE, WR_PAGE, then the registered result strobe on a hit or
//   an empty-frame fill; an eviction adds SCAN over the N frames in use
//   (1..16), DRAIN and EVICT. A new transfer is taken only once busy drops;
//   the time is set by the page record read-modify-write plus, on an eviction,
//   the one-read-per-cycle scan of the page record memory.
// Reset (rst_n low, synchronous): frames empty, all page records zero,
//   counters zero, frames_in_use = 4. No clearing pass; ready right after.
// ----------------------------------------------------------------------------
module lfu_lru_page_replacer_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  in_page_number,
  // result channel
  output logic        out_valid,
  output logic        out_is_hit,
  output logic [3:0]  out_frame_index,
  output logic        out_evicted_valid,
  output logic [5:0]  out_evicted_page,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_fault_total,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  lfulru_pkg::state_t       state_r, state_nxt;
  lfulru_pkg::cfg_frames_t  cfg_frames_r;
  lfulru_pkg::frame_idx_t   nf_last;
  lfulru_pkg::page_t        page_r;
  lfulru_pkg::lookup_t      lk, lk_r;
  lfulru_pkg::frame_idx_t   scan_idx_r, scan_idx_nxt;
  logic                     cmp_vld_r;
  lfulru_pkg::frame_idx_t   cmp_idx_r;
  lfulru_pkg::page_t        cmp_page_r;
  lfulru_pkg::stamp_t       access_r;
  lfulru_pkg::total_t       hit_cnt_r, fault_cnt_r;
  lfulru_pkg::total_t       hit_cnt_nxt, fault_cnt_nxt;

  // memory and frame table control, decoded from the state
  logic                     mem_rd_en;
  lfulru_pkg::page_t        mem_rd_addr;
  logic                     mem_wr_en;
  lfulru_pkg::page_t        mem_wr_addr;
  lfulru_pkg::page_rec_t    mem_wr_rec;
  lfulru_pkg::page_rec_t    mem_rd_rec;
  logic                     frm_wr_en;
  lfulru_pkg::frame_idx_t   frm_wr_idx;
  lfulru_pkg::page_t        frm_rd_page;
  logic                     finish;
  logic                     fin_hit;
  logic                     fin_evict;
  lfulru_pkg::use_cnt_t     cnt_inc;

  lfulru_pkg::frame_idx_t   best_idx;
  lfulru_pkg::page_t        best_page;
  lfulru_pkg::stamp_t       best_stamp;

  logic                     out_valid_r;
  logic                     out_is_hit_r;
  lfulru_pkg::frame_idx_t   out_frame_r;
  logic                     out_ev_vld_r;
  lfulru_pkg::page_t        out_ev_page_r;
  lfulru_pkg::total_t       out_hit_tot_r, out_fault_tot_r;

  // --------------------------------------------------------------------------
  // Configuration: frames_in_use, clamped to 1..MAX_FRAMES as a last index.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frames_r <= lfulru_pkg::FRAMES_RESET;
    end else if (cfg_wr_en) begin
      cfg_frames_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (cfg_frames_r == '0) begin
      nf_last = '0;
    end else if (cfg_frames_r > lfulru_pkg::CFG_W'(lfulru_pkg::MAX_FRAMES)) begin
      nf_last = lfulru_pkg::FRAME_W'(lfulru_pkg::MAX_FRAMES - 1);
    end else begin
      nf_last = lfulru_pkg::FRAME_W'(cfg_frames_r - 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Sub-blocks
  // --------------------------------------------------------------------------
  lfulru_page_mem u_page_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_rec  (mem_rd_rec),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_rec  (mem_wr_rec)
  );

  lfulru_frame_tbl u_frame_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .lk_page (page_r),
    .nf_last (nf_last),
    .lk      (lk),
    .rd_idx  (scan_idx_r),
    .rd_page (frm_rd_page),
    .wr_en   (frm_wr_en),
    .wr_idx  (frm_wr_idx),
    .wr_page (page_r)
  );

  lfulru_victim_sel u_victim_sel (
    .clk        (clk),
    .cmp_vld    (cmp_vld_r),
    .cmp_idx    (cmp_idx_r),
    .cmp_page   (cmp_page_r),
    .cmp_rec    (mem_rd_rec),
    .best_idx   (best_idx),
    .best_page  (best_page),
    .best_stamp (best_stamp)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state
  //   RD_PAGE  read the referenced page record, latch the frame lookup
  //   WR_PAGE  write back count+1 and stamp; finish on hit or empty frame
  //   SCAN     one record read per in-use frame
  //   DRAIN    last compare lands
  //   EVICT    clear victim count, hand its frame to the new page
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lfulru_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = lfulru_pkg::ST_RD_PAGE;
        end
      end
      lfulru_pkg::ST_RD_PAGE: state_nxt = lfulru_pkg::ST_WR_PAGE;
      lfulru_pkg::ST_WR_PAGE: begin
        state_nxt = lk_r.found ? lfulru_pkg::ST_IDLE : lfulru_pkg::ST_SCAN;
      end
      lfulru_pkg::ST_SCAN: begin
        if (scan_idx_r == nf_last) begin
          state_nxt = lfulru_pkg::ST_DRAIN;
        end
      end
      lfulru_pkg::ST_DRAIN: state_nxt = lfulru_pkg::ST_EVICT;
      lfulru_pkg::ST_EVICT: state_nxt = lfulru_pkg::ST_IDLE;
      default: state_nxt = lfulru_pkg::ST_IDLE;
    endcase
  end

  // Saturating use-count bump of the record read in RD_PAGE.
  assign cnt_inc = (mem_rd_rec.cnt == lfulru_pkg::USE_CNT_MAX) ?
                   mem_rd_rec.cnt : mem_rd_rec.cnt + 1'b1;

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    mem_rd_en    = 1'b0;
    mem_rd_addr  = page_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = page_r;
    mem_wr_rec   = '{cnt: cnt_inc, stamp: access_r};
    frm_wr_en    = 1'b0;
    frm_wr_idx   = lk_r.slot;
    finish       = 1'b0;
    fin_hit      = 1'b0;
    fin_evict    = 1'b0;
    scan_idx_nxt = scan_idx_r;
    case (state_r)
      lfulru_pkg::ST_RD_PAGE: begin
        mem_rd_en = 1'b1;
      end
      lfulru_pkg::ST_WR_PAGE: begin
        mem_wr_en    = 1'b1;
        scan_idx_nxt = '0;
        if (lk_r.found) begin
          frm_wr_en = 1'b1;
          finish    = 1'b1;
          fin_hit   = lk_r.hit;
        end
      end
      lfulru_pkg::ST_SCAN: begin
        mem_rd_en    = 1'b1;
        mem_rd_addr  = frm_rd_page;
        scan_idx_nxt = scan_idx_r + 1'b1;
      end
      lfulru_pkg::ST_EVICT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = best_page;
        mem_wr_rec  = '{cnt: '0, stamp: best_stamp};
        frm_wr_en   = 1'b1;
        frm_wr_idx  = best_idx;
        finish      = 1'b1;
        fin_evict   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Saturating totals, advanced on the finishing cycle.
  always_comb begin
    hit_cnt_nxt   = hit_cnt_r;
    fault_cnt_nxt = fault_cnt_r;
    if (finish) begin
      if (fin_hit) begin
        if (hit_cnt_r != lfulru_pkg::TOTAL_MAX) begin
          hit_cnt_nxt = hit_cnt_r + 1'b1;
        end
      end else if (fault_cnt_r != lfulru_pkg::TOTAL_MAX) begin
        fault_cnt_nxt = fault_cnt_r + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfulru_pkg::ST_IDLE;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      access_r    <= '0;
      hit_cnt_r   <= '0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      // Read data of a SCAN read is compared in the following cycle.
      cmp_vld_r   <= (state_r == lfulru_pkg::ST_SCAN);
      hit_cnt_r   <= hit_cnt_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      out_valid_r <= finish;
      if ((state_r == lfulru_pkg::ST_WR_PAGE) && (access_r != lfulru_pkg::STAMP_MAX)) begin
        access_r <= access_r + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if ((state_r == lfulru_pkg::ST_IDLE) && start) begin
      page_r <= in_page_number;
    end
    if (state_r == lfulru_pkg::ST_RD_PAGE) begin
      lk_r <= lk;
    end
    cmp_idx_r  <= scan_idx_r;
    cmp_page_r <= frm_rd_page;
    if (finish) begin
      out_is_hit_r    <= fin_hit;
      out_frame_r     <= frm_wr_idx;
      out_ev_vld_r    <= fin_evict;
      out_ev_page_r   <= fin_evict ? best_page : '0;
      out_hit_tot_r   <= hit_cnt_nxt;
      out_fault_tot_r <= fault_cnt_nxt;
    end
  end

  assign busy              = (state_r != lfulru_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_is_hit        = out_is_hit_r;
  assign out_frame_index   = out_frame_r;
  assign out_evicted_valid = out_ev_vld_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_hit_total     = out_hit_tot_r;
  assign out_fault_total   = out_fault_tot_r;

endmodule

FILE: rtl/core/lfulru_checker.sv
// ----------------------------------------------------------------------------
// lfulru_checker
// Port-level checks on the page replacer, bound to the top level.
// ----------------------------------------------------------------------------
module lfulru_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_is_hit,
  input logic        out_evicted_valid,
  input logic [5:0]  out_evicted_page
);

  // An accepted item keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  // Results are strobed only after the sequencer is back at rest.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // One item gives one strobe: never two in a row.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_hit) |-> !out_evicted_valid)
    else $error("hit reported with eviction");

  // No eviction means evicted page reads zero.
  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted_valid) |-> (out_evicted_page == 6'd0))
    else $error("evicted page nonzero without eviction");

endmodule

bind lfu_lru_page_replacer_top lfulru_checker u_lfulru_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_is_hit        (out_is_hit),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LFU page replacer with LRU tie-break. A
// cycle-free model tracks frames, per-page use counts and last-use stamps,
// predicts each outcome and checks it against the result strobe. Page
// references come in directed form first, then as random working sets under
// many frame settings, with random gaps on the request side.
// ----------------------------------------------------------------------------
module tb_top;
  import lfulru_pkg::*;

  // One predicted or observed outcome of a page reference.
  typedef struct {
    logic       is_hit;
    frame_idx_t frame_index;
    logic       evicted_valid;
    page_t      evicted_page;
    total_t     hit_total;
    total_t     fault_total;
  } outcome_t;

  // Replacement model plus the queue of outcomes still owed by the block.
  class replacement_tracker;
    cfg_frames_t frames_cfg;
    page_t       frame_page [MAX_FRAMES];
    bit          frame_valid [MAX_FRAMES];
    use_cnt_t    use_cnt [PAGE_SPACE];
    stamp_t      last_use [PAGE_SPACE];
    stamp_t      access_num;
    total_t      hit_cnt;
    total_t      fault_cnt;
    outcome_t    awaiting [$];
    int unsigned mismatches;

    function new();
      frames_cfg = FRAMES_RESET;
      foreach (frame_page[i]) begin
        frame_page[i]  = '0;
        frame_valid[i] = 1'b0;
      end
      foreach (use_cnt[i]) begin
        use_cnt[i]  = '0;
        last_use[i] = '0;
      end
      access_num = '0;
      hit_cnt    = '0;
      fault_cnt  = '0;
      mismatches = 0;
    endfunction

    function void set_frames(cfg_frames_t v);
      frames_cfg = v;
    endfunction

    function int unsigned outstanding();
      return awaiting.size();
    endfunction

    // Apply one reference to the model and queue the outcome it must produce.
    function void note_reference(page_t page);
      int unsigned nf;
      int unsigned slot;
      int unsigned best;
      bit          found;
      bit          hit;
      page_t       pj;
      page_t       pb;
      outcome_t    o;
      nf = (frames_cfg == 0) ? 1 :
           (frames_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(frames_cfg);
      if (use_cnt[page] != USE_CNT_MAX) use_cnt[page]++;
      last_use[page] = access_num;
      if (access_num != STAMP_MAX) access_num++;
      found = 1'b0;
      hit   = 1'b0;
      slot  = 0;
      for (int unsigned j = 0; j < nf; j++) begin
        if (!found && (!frame_valid[j] || frame_page[j] == page)) begin
          found = 1'b1;
          hit   = frame_valid[j];
          slot  = j;
        end
      end
      o = '{default: '0};
      if (!found) begin
        // Victim: least use count, then earliest last use, then lowest index.
        best = 0;
        for (int unsigned j = 1; j < nf; j++) begin
          pj = frame_page[j];
          pb = frame_page[best];
          if (use_cnt[pj] < use_cnt[pb] ||
              (use_cnt[pj] == use_cnt[pb] && last_use[pj] < last_use[pb]))
            best = j;
        end
        slot            = best;
        o.evicted_valid = 1'b1;
        o.evicted_page  = frame_page[slot];
        use_cnt[frame_page[slot]] = '0;
      end
      frame_page[slot]  = page;
      frame_valid[slot] = 1'b1;
      if (hit) begin
        if (hit_cnt != TOTAL_MAX) hit_cnt++;
      end else begin
        if (fault_cnt != TOTAL_MAX) fault_cnt++;
      end
      o.is_hit      = hit;
      o.frame_index = slot[FRAME_W-1:0];
      o.hit_total   = hit_cnt;
      o.fault_total = fault_cnt;
      awaiting.push_back(o);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one strobed result against the oldest outstanding outcome.
    function void check_outcome(outcome_t got);
      outcome_t want;
      if (awaiting.size() == 0) begin
        $error("result strobe with no reference outstanding");
        mismatches++;
        return;
      end
      want = awaiting.pop_front();
      compare_field("is_hit", 32'(want.is_hit), 32'(got.is_hit));
      compare_field("frame_index", 32'(want.frame_index), 32'(got.frame_index));
      compare_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
      compare_field("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
      compare_field("hit_total", want.hit_total, got.hit_total);
      compare_field("fault_total", want.fault_total, got.fault_total);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  page_t       in_page_number;
  logic        out_valid;
  logic        out_is_hit;
  frame_idx_t  out_frame_index;
  logic        out_evicted_valid;
  page_t       out_evicted_page;
  total_t      out_hit_total;
  total_t      out_fault_total;
  logic        cfg_wr_en;
  cfg_frames_t cfg_wr_data;

  replacement_tracker tracker;
  outcome_t           seen;
  int unsigned        refs_sent;

  lfu_lru_page_replacer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_is_hit        (out_is_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total),
    .out_fault_total   (out_fault_total),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  // 4 ns clock.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run (all evictions at 16 frames).
  initial begin
    #2000000;
    $display("lfu_lru_page_replacer_top verification failed");
    $finish;
  end

  // Result monitor: the strobe lasts one cycle and cannot be held off, so
  // sample it at every edge once reset has been released.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen.is_hit        = out_is_hit;
      seen.frame_index   = out_frame_index;
      seen.evicted_valid = out_evicted_valid;
      seen.evicted_page  = out_evicted_page;
      seen.hit_total     = out_hit_total;
      seen.fault_total   = out_fault_total;
      tracker.check_outcome(seen);
    end
  end

  // Present one page reference and hold it until the transfer happens. Start
  // stays high on return so back-to-back references keep it asserted; when
  // a gap is allowed, now and then drop start for a random gap.
  task automatic issue_page(input page_t page, input bit allow_gap);
    start          <= 1'b1;
    in_page_number <= page;
    do @(posedge clk); while (busy);
    tracker.note_reference(page);
    refs_sent++;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Write the frame count only with nothing in flight: every reference owes
  // exactly one result, so an empty queue and busy low mean idle.
  task automatic program_frames(input cfg_frames_t value);
    start <= 1'b0;
    while (tracker.outstanding() != 0 || busy) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_frames(value);
  endtask

  // Pick a page: mostly from a working set sized around the frame count so
  // that hits, fills and evictions all occur; otherwise anywhere.
  function automatic page_t pick_page(int unsigned base, int unsigned spread);
    if ($urandom_range(0, 9) < 7)
      return page_t'(base + $urandom_range(0, spread - 1));
    return page_t'($urandom_range(0, PAGE_SPACE - 1));
  endfunction

  initial begin
    int unsigned nf;
    int unsigned base;
    int unsigned spread;
    int unsigned burst;
    int unsigned guard;
    cfg_frames_t setting;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_page_number = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    refs_sent      = 0;
    tracker        = new();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset setting of four frames. Fill with the lowest and
    // highest pages, hit, then force an eviction decided by last use.
    issue_page(6'd0, 1'b0);
    issue_page(6'd63, 1'b0);
    issue_page(6'd0, 1'b0);
    issue_page(6'd21, 1'b0);
    issue_page(6'd42, 1'b0);
    issue_page(6'd63, 1'b0);
    issue_page(6'd1, 1'b0);
    issue_page(6'd21, 1'b0);

    // Zero frames acts as one: every new page evicts frame 0.
    program_frames(5'd0);
    issue_page(6'd5, 1'b0);
    issue_page(6'd5, 1'b0);
    issue_page(6'd6, 1'b0);

    // Top of the register range clamps to the full frame count.
    program_frames(5'd31);
    issue_page(6'd10, 1'b0);
    issue_page(6'd11, 1'b1);
    issue_page(6'd10, 1'b0);

    // Explicit extremes, then back to four: frames beyond the range keep
    // their pages and come back into play when the range widens again.
    program_frames(5'd1);
    issue_page(6'd10, 1'b0);
    issue_page(6'd7, 1'b0);
    program_frames(5'd16);
    issue_page(6'd11, 1'b0);
    issue_page(6'd12, 1'b1);
    program_frames(5'd4);
    issue_page(6'd42, 1'b0);
    issue_page(6'd33, 1'b0);
    program_frames(5'd16);
    issue_page(6'd12, 1'b0);

    // Random phases: a new frame setting, then a burst of references drawn
    // from a working set a little smaller or larger than the frame count.
    // The last stretch runs with no gaps.
    while (refs_sent < 800) begin
      case ($urandom_range(0, 9))
        0:       setting = 5'd0;
        1:       setting = 5'd1;
        2:       setting = 5'd16;
        3:       setting = cfg_frames_t'($urandom_range(17, 31));
        default: setting = cfg_frames_t'($urandom_range(1, 16));
      endcase
      program_frames(setting);
      nf     = (setting == 0) ? 1 : (setting > MAX_FRAMES) ? MAX_FRAMES : setting;
      base   = $urandom_range(0, PAGE_SPACE - 1);
      spread = $urandom_range((nf > 2) ? nf - 2 : 1, nf + 4);
      burst  = $urandom_range(30, 100);
      for (int unsigned i = 0; i < burst; i++)
        issue_page(pick_page(base, spread), refs_sent < 700);
    end

    // Drain: wait for every owed result, then cover the longest latency.
    start <= 1'b0;
    guard = 0;
    while (tracker.outstanding() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (24) @(posedge clk);
    if (tracker.outstanding() != 0) begin
      $error("%0d results never arrived", tracker.outstanding());
      tracker.mismatches++;
    end

    if (tracker.mismatches == 0) begin
      $display("lfu_lru_page_replacer_top verification clean");
    end else begin
      $display("lfu_lru_page_replacer_top verification failed");
    end
    $finish;
  end

endmodule
